// File: design/two_body_rk4_orbit_step_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-body orbit step unit
// Concurrent checks sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TWO_BODY_RK4_ORBIT_STEP_UNIT_MACROS_SVH
`define TWO_BODY_RK4_ORBIT_STEP_UNIT_MACROS_SVH

// Same-cycle implication
`define TBRK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TBRK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tbrk_pkg.sv
// ----------------------------------------------------------------------------
// tbrk_pkg
// Shared constants, types and fixed-point helpers of the orbit step unit.
// ----------------------------------------------------------------------------
package tbrk_pkg;

  localparam int FRAC_BITS = 32;
  localparam int STEP_W    = 42;
  localparam int MU_W      = 62;
  localparam int CFG_W     = 62;

  localparam logic [STEP_W-1:0] STEP_RESET = 42'd67108864;
  localparam logic [MU_W-1:0]   MU_RESET   = 62'd1711975861702152;

  // register indexes
  localparam logic REG_STEP = 1'b0;
  localparam logic REG_MU   = 1'b1;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [63:0] val;
    logic               sat;
  } sres_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // magnitude of a signed word
  function automatic logic [63:0] mag(input logic signed [63:0] a);
    mag = a[63] ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

  // saturating signed add
  function automatic sres_t sat_add(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
    sres_t       r;
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r.val = a[63] ? S64_MIN : S64_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = s[63:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // signed word from magnitude and sign, saturating
  function automatic sres_t pack_mag(input logic [127:0] m, input logic neg);
    sres_t r;
    if (neg) begin
      if (m[127:64] != '0 || m[63:0] > 64'h8000_0000_0000_0000) begin
        r.val = S64_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = 64'd0 - m[63:0];
        r.sat = 1'b0;
      end
    end else if (m[127:63] != '0) begin
      r.val = S64_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = m[63:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // round to nearest on the magnitude; half selects one extra fraction bit
  function automatic logic [127:0] round_shift(input logic [127:0] p, input logic half);
    if (half) round_shift = (p + (128'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
    else      round_shift = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

endpackage

// File: design/tbrk_req_if.sv
// ----------------------------------------------------------------------------
// tbrk_req_if
// Request channel: item kind and state words for a load.
// ----------------------------------------------------------------------------
interface tbrk_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [63:0] load_px;
  logic signed [63:0] load_py;
  logic signed [63:0] load_pz;
  logic signed [63:0] load_vx;
  logic signed [63:0] load_vy;
  logic signed [63:0] load_vz;

  modport source (output valid, kind, load_px, load_py, load_pz,
                  load_vx, load_vy, load_vz, input ready);
  modport sink   (input valid, kind, load_px, load_py, load_pz,
                  load_vx, load_vy, load_vz, output ready);
endinterface

// File: design/tbrk_rsp_if.sv
// ----------------------------------------------------------------------------
// tbrk_rsp_if
// Response channel: state after the item and status flags.
// ----------------------------------------------------------------------------
interface tbrk_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] out_px;
  logic signed [63:0] out_py;
  logic signed [63:0] out_pz;
  logic signed [63:0] out_vx;
  logic signed [63:0] out_vy;
  logic signed [63:0] out_vz;
  logic               stalled;
  logic               saturated;

  modport source (output valid, out_px, out_py, out_pz, out_vx, out_vy, out_vz,
                  stalled, saturated, input ready);
  modport sink   (input valid, out_px, out_py, out_pz, out_vx, out_vy, out_vz,
                  stalled, saturated, output ready);
endinterface

// File: design/tbrk_mul.sv
// ----------------------------------------------------------------------------
// tbrk_mul
// Unsigned 64x64 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module tbrk_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output logic [127:0]        prod,
  output tbrk_pkg::unit_stat_t stat
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [1:0]   cnt;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  // pick the partial product for this cycle
  always_comb begin
    case (cnt)
      2'd0:    pp = a_r[31:0]  * b_r[31:0];
      2'd1:    pp = a_r[31:0]  * b_r[63:32];
      2'd2:    pp = a_r[63:32] * b_r[31:0];
      default: pp = a_r[63:32] * b_r[63:32];
    endcase
    case (cnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // accumulate partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == 2'd3);
      if (start) begin
        a_r       <= a;
        b_r       <= b;
        prod      <= '0;
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        prod <= prod + pp_sh;
        cnt  <= cnt + 2'd1;
        if (cnt == 2'd3) stat.busy <= 1'b0;
      end
    end
  end

endmodule

// File: design/tbrk_div.sv
// ----------------------------------------------------------------------------
// tbrk_div
// Restoring divider, 128 by 64 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbrk_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         num_hi,
  input  logic [63:0]         num_lo,
  input  logic [63:0]         den,
  output logic [63:0]         quo,
  output logic                over,
  output tbrk_pkg::unit_stat_t stat
);

  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] den_r;
  logic [5:0]  cnt;
  logic [64:0] rem_s;
  logic        take;

  // shift in the next numerator bit and compare
  always_comb begin
    rem_s = {rem, lo[63]};
    take  = (rem_s >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= start ? (num_hi >= den) : (stat.busy && (cnt == 6'd0));
      if (start) begin
        den_r <= den;
        rem   <= num_hi;
        lo    <= num_lo;
        cnt   <= 6'd63;
        // quotient would not fit in 64 bits
        if (num_hi >= den) begin
          over <= 1'b1;
          quo  <= '1;
        end else begin
          over      <= 1'b0;
          quo       <= '0;
          stat.busy <= 1'b1;
        end
      end else if (stat.busy) begin
        rem <= take ? 64'(rem_s - {1'b0, den_r}) : rem_s[63:0];
        quo <= {quo[62:0], take};
        lo  <= {lo[62:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) stat.busy <= 1'b0;
      end
    end
  end

endmodule

// File: design/tbrk_sqrt.sv
// ----------------------------------------------------------------------------
// tbrk_sqrt
// Integer square root of a 128-bit word, one root bit per cycle.
// ----------------------------------------------------------------------------
module tbrk_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [127:0]        rad,
  output logic [63:0]         root,
  output tbrk_pkg::unit_stat_t stat
);

  logic [127:0] x;
  logic [67:0]  rem;
  logic [5:0]   cnt;
  logic [67:0]  rem_s;
  logic [67:0]  trial;
  logic         take;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_s = {rem[65:0], x[127:126]};
    trial = {2'b00, root, 2'b01};
    take  = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == 6'd0);
      if (start) begin
        x         <= rad;
        rem       <= '0;
        root      <= '0;
        cnt       <= 6'd63;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem  <= take ? (rem_s - trial) : rem_s;
        root <= {root[62:0], take};
        x    <= {x[125:0], 2'b00};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) stat.busy <= 1'b0;
      end
    end
  end

endmodule

// File: design/two_body_rk4_orbit_step_unit.sv
// ----------------------------------------------------------------------------
// two_body_rk4_orbit_step_unit
// Two-body orbit propagator: one fourth-order Runge-Kutta step per step word.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per item: kind selects a load of the six state
//   components (position km, velocity km/s, signed Q32.32) or one RK4 step
//   under point-mass gravity. rsp returns one word per item: the state after
//   it, a stalled flag (increment zero in every component, state kept) and a
//   saturated flag. cfg_we/cfg_index/cfg_data write the step size (index 0) and the
//   gravitational parameter (index 1); the user must write only while the unit is idle, unchecked by the block.
// Sequencing:
//   A load word passes through S_OUT into the rsp register. For a step word
//   each of the four derivative evaluations runs three squarings, a square
//   root and five divisions on the shared radix-2 divider (no divisions at
//   zero radius), each stage update works through the components in turn,
//   and the final scaling multiplies by the reciprocal of six. One word is in
//   work at a time; req.ready is high only while idle.
// Reset:
//   rst clears the state to zero and loads the default step size and mu.
// Stall:
//   A finished word waits in the rsp register; the next req word is taken
//   meanwhile and its result holds until rsp.ready frees the register.
// ----------------------------------------------------------------------------
`include "two_body_rk4_orbit_step_unit_macros.svh"

module two_body_rk4_orbit_step_unit (
  input  logic                        clk,
  input  logic                        rst,
  tbrk_req_if.sink                    req,
  tbrk_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tbrk_pkg::CFG_W-1:0]  cfg_data
);

  // floor(x / 6) for any 64-bit x is (x * RECIP6) >> 66
  localparam logic [63:0] RECIP6 = 64'hAAAA_AAAA_AAAA_AAAB;

  typedef enum logic [4:0] {
    S_IDLE, S_DV_INIT, S_SQ_GO, S_SQ_WAIT, S_RT_GO, S_RT_WAIT,
    S_GM_GO, S_GM_WAIT, S_GN_GO, S_GN_WAIT, S_UD_GO, S_UD_WAIT,
    S_UM_GO, S_UM_WAIT, S_UM_RND, S_ACC, S_ST_GO, S_ST_WAIT, S_ST_RND,
    S_ST_ADD, S_FM_GO, S_FM_WAIT, S_FM_RND, S_F6_GO, S_F6_WAIT, S_UPD, S_OUT
  } state_t;

  state_t state;

  logic [tbrk_pkg::STEP_W-1:0] step_r;
  logic [tbrk_pkg::MU_W-1:0]   mu_r;

  logic signed [63:0] xs   [6];
  logic signed [63:0] ts   [6];
  logic signed [63:0] ks   [6];
  logic signed [63:0] ksum [6];
  logic signed [63:0] out_r[6];
  logic [127:0]       r2;
  logic [63:0]        nrm;
  logic signed [63:0] g;
  logic signed [63:0] tmp;
  logic [2:0]         idx;
  logic [1:0]         rk;
  logic               sat;
  logic               nz;
  logic               stall;
  logic               out_valid;
  logic               out_stalled;
  logic               out_sat;

  // shared unit ports
  logic                 mul_start;
  logic [63:0]          mul_a;
  logic [63:0]          mul_b;
  logic [127:0]         mul_prod;
  tbrk_pkg::unit_stat_t mul_st;
  logic                 div_start;
  logic [63:0]          div_hi;
  logic [63:0]          div_lo;
  logic [63:0]          div_den;
  logic [63:0]          div_q;
  logic                 div_over;
  tbrk_pkg::unit_stat_t div_st;
  logic                 sq_start;
  logic [63:0]          sq_root;
  tbrk_pkg::unit_stat_t sq_st;

  logic [63:0]          div_m;
  logic                 div_neg;
  logic                 rnd_half;
  logic                 rnd_neg;
  tbrk_pkg::sres_t      rnd_pk;
  tbrk_pkg::sres_t      div_pk;
  tbrk_pkg::sres_t      dbl_pk;
  tbrk_pkg::sres_t      add_pk;
  logic signed [63:0]   add_a;
  logic signed [63:0]   add_b;
  logic [63:0]          q6;
  logic signed [63:0]   d_val;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_r <= tbrk_pkg::STEP_RESET;
      mu_r   <= tbrk_pkg::MU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tbrk_pkg::REG_STEP: step_r <= cfg_data[tbrk_pkg::STEP_W-1:0];
        tbrk_pkg::REG_MU:   mu_r   <= cfg_data[tbrk_pkg::MU_W-1:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = tbrk_pkg::mag(ts[idx]);
        mul_b     = tbrk_pkg::mag(ts[idx]);
      end
      S_UM_GO: begin
        mul_start = 1'b1;
        mul_a     = tbrk_pkg::mag(g);
        mul_b     = tbrk_pkg::mag(tmp);
      end
      S_ST_GO: begin
        mul_start = 1'b1;
        mul_a     = tbrk_pkg::mag(ks[idx]);
        mul_b     = 64'(step_r);
      end
      S_FM_GO: begin
        mul_start = 1'b1;
        mul_a     = tbrk_pkg::mag(ksum[idx]);
        mul_b     = 64'(step_r);
      end
      // rounded divide by six through the reciprocal
      S_F6_GO: begin
        mul_start = 1'b1;
        mul_a     = tbrk_pkg::mag(tmp) + 64'd3;
        mul_b     = RECIP6;
      end
      default: ;
    endcase
  end

  // divider operand select: fixed-point divide by |r|
  always_comb begin
    div_start = 1'b0;
    div_m     = '0;
    div_den   = nrm;
    case (state)
      S_GM_GO: begin
        div_start = 1'b1;
        div_m     = 64'(mu_r);
      end
      S_GN_GO: begin
        div_start = 1'b1;
        div_m     = tbrk_pkg::mag(g);
      end
      S_UD_GO: begin
        div_start = 1'b1;
        div_m     = tbrk_pkg::mag(ts[idx]);
      end
      default: ;
    endcase
    div_hi = div_m >> (64 - tbrk_pkg::FRAC_BITS);
    div_lo = div_m << tbrk_pkg::FRAC_BITS;
  end

  assign sq_start = (state == S_RT_GO);

  // rounding, packing and saturating add paths
  always_comb begin
    rnd_half = (state == S_ST_RND) && (rk != 2'd2);
    case (state)
      S_UM_RND: rnd_neg = ~tmp[63];
      S_ST_RND: rnd_neg = ks[idx][63];
      default:  rnd_neg = ksum[idx][63];
    endcase
    rnd_pk  = tbrk_pkg::pack_mag(tbrk_pkg::round_shift(mul_prod, rnd_half), rnd_neg);
    div_neg = (state == S_UD_WAIT) ? ts[idx][63] : 1'b0;
    div_pk  = tbrk_pkg::pack_mag({63'd0, div_over, div_q}, div_neg);
    dbl_pk  = tbrk_pkg::sat_add(ks[idx], ks[idx]);
    case (state)
      S_ST_ADD: begin
        add_a = xs[idx];
        add_b = tmp;
      end
      S_UPD: begin
        add_a = xs[idx];
        add_b = ks[idx];
      end
      default: begin
        add_a = ksum[idx];
        add_b = (rk == 2'd3) ? ks[idx] : dbl_pk.val;
      end
    endcase
    add_pk = tbrk_pkg::sat_add(add_a, add_b);
    q6     = {2'b00, mul_prod[127:66]};
    d_val  = tmp[63] ? (64'sd0 - $signed(q6)) : $signed(q6);
  end

  tbrk_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_st)
  );

  tbrk_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .quo    (div_q),
    .over   (div_over),
    .stat   (div_st)
  );

  tbrk_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (r2),
    .root  (sq_root),
    .stat  (sq_st)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      rk        <= '0;
      sat       <= 1'b0;
      nz        <= 1'b0;
      stall     <= 1'b0;
      for (int i = 0; i < 6; i++) xs[i] <= '0;
    end else begin
      // drop the result word once taken
      if (rsp.ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            sat   <= 1'b0;
            nz    <= 1'b0;
            stall <= 1'b0;
            rk    <= '0;
            if (req.kind == tbrk_pkg::KIND_LOAD) begin
              xs[0] <= req.load_px;
              xs[1] <= req.load_py;
              xs[2] <= req.load_pz;
              xs[3] <= req.load_vx;
              xs[4] <= req.load_vy;
              xs[5] <= req.load_vz;
              state <= S_OUT;
            end else begin
              for (int i = 0; i < 6; i++) ts[i] <= xs[i];
              state <= S_DV_INIT;
            end
          end
        end
        // start a derivative evaluation at ts
        S_DV_INIT: begin
          r2    <= '0;
          idx   <= '0;
          ks[0] <= ts[3];
          ks[1] <= ts[4];
          ks[2] <= ts[5];
          state <= S_SQ_GO;
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (mul_st.done) begin
            r2 <= r2 + mul_prod;
            if (idx == 3'd2) begin
              idx   <= '0;
              state <= S_RT_GO;
            end else begin
              idx   <= idx + 3'd1;
              state <= S_SQ_GO;
            end
          end
        end
        S_RT_GO: state <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (sq_st.done) begin
            nrm <= sq_root;
            // zero radius: no acceleration, flag it
            if (sq_root == '0) begin
              ks[3] <= '0;
              ks[4] <= '0;
              ks[5] <= '0;
              sat   <= 1'b1;
              idx   <= '0;
              state <= S_ACC;
            end else begin
              state <= S_GM_GO;
            end
          end
        end
        S_GM_GO: state <= S_GM_WAIT;
        S_GM_WAIT: begin
          if (div_st.done) begin
            g     <= div_pk.val;
            sat   <= sat | div_pk.sat;
            state <= S_GN_GO;
          end
        end
        S_GN_GO: state <= S_GN_WAIT;
        S_GN_WAIT: begin
          if (div_st.done) begin
            g     <= div_pk.val;
            sat   <= sat | div_pk.sat;
            idx   <= '0;
            state <= S_UD_GO;
          end
        end
        // unit vector component, then scale by -g
        S_UD_GO: state <= S_UD_WAIT;
        S_UD_WAIT: begin
          if (div_st.done) begin
            tmp   <= div_pk.val;
            sat   <= sat | div_pk.sat;
            state <= S_UM_GO;
          end
        end
        S_UM_GO: state <= S_UM_WAIT;
        S_UM_WAIT: if (mul_st.done) state <= S_UM_RND;
        S_UM_RND: begin
          ks[3'd3 + idx] <= rnd_pk.val;
          sat            <= sat | rnd_pk.sat;
          if (idx == 3'd2) begin
            idx   <= '0;
            state <= S_ACC;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_UD_GO;
          end
        end
        // weighted slope sum k1 + 2k2 + 2k3 + k4
        S_ACC: begin
          case (rk)
            2'd0: ksum[idx] <= ks[idx];
            2'd3: begin
              ksum[idx] <= add_pk.val;
              sat       <= sat | add_pk.sat;
            end
            default: begin
              ksum[idx] <= add_pk.val;
              sat       <= sat | add_pk.sat | dbl_pk.sat;
            end
          endcase
          if (idx == 3'd5) begin
            idx   <= '0;
            state <= (rk == 2'd3) ? S_FM_GO : S_ST_GO;
          end else begin
            idx <= idx + 3'd1;
          end
        end
        // next evaluation point x + h*k (half step for the first two)
        S_ST_GO: state <= S_ST_WAIT;
        S_ST_WAIT: if (mul_st.done) state <= S_ST_RND;
        S_ST_RND: begin
          tmp   <= rnd_pk.val;
          sat   <= sat | rnd_pk.sat;
          state <= S_ST_ADD;
        end
        S_ST_ADD: begin
          ts[idx] <= add_pk.val;
          sat     <= sat | add_pk.sat;
          if (idx == 3'd5) begin
            rk    <= rk + 2'd1;
            state <= S_DV_INIT;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_ST_GO;
          end
        end
        // increment = round(ksum * h / 6)
        S_FM_GO: state <= S_FM_WAIT;
        S_FM_WAIT: if (mul_st.done) state <= S_FM_RND;
        S_FM_RND: begin
          tmp   <= rnd_pk.val;
          sat   <= sat | rnd_pk.sat;
          state <= S_F6_GO;
        end
        S_F6_GO: state <= S_F6_WAIT;
        S_F6_WAIT: begin
          if (mul_st.done) begin
            ks[idx] <= d_val;
            nz      <= nz | (q6 != '0);
            if (idx == 3'd5) begin
              idx <= '0;
              if (nz || q6 != '0) begin
                state <= S_UPD;
              end else begin
                stall <= 1'b1;
                state <= S_OUT;
              end
            end else begin
              idx   <= idx + 3'd1;
              state <= S_FM_GO;
            end
          end
        end
        // advance the state
        S_UPD: begin
          xs[idx] <= add_pk.val;
          sat     <= sat | add_pk.sat;
          if (idx == 3'd5) state <= S_OUT;
          else             idx   <= idx + 3'd1;
        end
        // hold until the result register is free
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            for (int i = 0; i < 6; i++) out_r[i] <= xs[i];
            out_stalled <= stall;
            out_sat     <= sat;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.out_px    = out_r[0];
  assign rsp.out_py    = out_r[1];
  assign rsp.out_pz    = out_r[2];
  assign rsp.out_vx    = out_r[3];
  assign rsp.out_vy    = out_r[4];
  assign rsp.out_vz    = out_r[5];
  assign rsp.stalled   = out_stalled;
  assign rsp.saturated = out_sat;

  // checks
  `TBRK_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "took a word while busy")
  `TBRK_ASSERT_IMP(a_one_unit, 1'b1, $onehot0({mul_st.busy, div_st.busy, sq_st.busy}), "shared units overlap")
  `TBRK_ASSERT_IMP(a_rsp_from_out, $rose(rsp.valid), $past(state == S_OUT), "result word outside output state")

endmodule

// File: sim/tb_two_body_rk4_orbit_step_unit.sv
// ----------------------------------------------------------------------------
// tb_two_body_rk4_orbit_step_unit
// Self-checking bench for the orbit step unit. Load and step words go in
// through the request channel. A fixed-point RK4 predictor in this file
// computes the state after each accepted word, and the response channel is
// checked against it field by field. The step size and mu are swept between
// phases, including their extremes.
// ----------------------------------------------------------------------------
module tb_two_body_rk4_orbit_step_unit;

  typedef logic signed [63:0] word_t;

  typedef struct {
    logic  kind;
    word_t comp [6];
  } orbit_word_t;

  typedef struct {
    word_t comp [6];
    logic  stalled;
    logic  saturated;
  } orbit_result_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [tbrk_pkg::CFG_W-1:0] cfg_data;

  tbrk_req_if req_ch ();
  tbrk_rsp_if rsp_ch ();

  two_body_rk4_orbit_step_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch.sink),
    .rsp       (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  orbit_word_t   orbit_pending [$];
  orbit_result_t state_expect_q [$];
  int            errors = 0;
  bit            calm = 1'b0;
  int            send_gap;
  int            recv_gap;

  // predictor state and registers
  word_t        orbit_st [6];
  logic [41:0]  step_h;
  logic [61:0]  grav_mu;
  logic         step_sat;

  // --------------------------------------------------------------------------
  // fixed-point arithmetic of the predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] fx_abs(input word_t a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic word_t fx_pack(input logic [127:0] m, input logic neg);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) begin
        step_sat = 1'b1;
        return tbrk_pkg::S64_MIN;
      end
      return 64'd0 - m[63:0];
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin
      step_sat = 1'b1;
      return tbrk_pkg::S64_MAX;
    end
    return m[63:0];
  endfunction

  function automatic word_t fx_add(input word_t a, input word_t b);
    word_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      step_sat = 1'b1;
      return a[63] ? tbrk_pkg::S64_MIN : tbrk_pkg::S64_MAX;
    end
    return r;
  endfunction

  function automatic word_t fx_mul(input word_t a, input word_t b, input int sh);
    logic [127:0] p;
    p = {64'd0, fx_abs(a)} * {64'd0, fx_abs(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    return fx_pack(p, a[63] ^ b[63]);
  endfunction

  function automatic word_t fx_div(input word_t a, input logic [63:0] d);
    logic [127:0] num;
    num = {64'd0, fx_abs(a)} << tbrk_pkg::FRAC_BITS;
    return fx_pack(num / {64'd0, d}, a[63]);
  endfunction

  function automatic logic [63:0] fx_isqrt(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  // state derivative: velocity, then point-mass gravity
  function automatic void orbit_rate(input word_t s [6], output word_t k [6]);
    logic [127:0] r2;
    logic [63:0]  n;
    word_t        g;
    r2 = '0;
    for (int i = 0; i < 3; i++) begin
      k[i] = s[3+i];
      r2 = r2 + {64'd0, fx_abs(s[i])} * {64'd0, fx_abs(s[i])};
    end
    n = fx_isqrt(r2);
    if (n == 0) begin
      for (int i = 3; i < 6; i++) k[i] = '0;
      step_sat = 1'b1;
      return;
    end
    g = fx_div(fx_div(word_t'({2'b00, grav_mu}), n), n);
    for (int i = 0; i < 3; i++)
      k[3+i] = fx_mul(-g, fx_div(s[i], n), tbrk_pkg::FRAC_BITS);
  endfunction

  function automatic void rk4_stage(input word_t x [6], input word_t k [6], input int sh,
                                    output word_t t [6]);
    word_t h;
    h = {22'd0, step_h};
    for (int i = 0; i < 6; i++) t[i] = fx_add(x[i], fx_mul(k[i], h, sh));
  endfunction

  // apply one accepted word to the predictor and return the result
  function automatic orbit_result_t predict_orbit(input orbit_word_t w);
    orbit_result_t res;
    word_t k1 [6], k2 [6], k3 [6], k4 [6], t [6], d [6], x [6];
    word_t sum, p, h;
    logic  all_zero;
    step_sat = 1'b0;
    res.stalled = 1'b0;
    if (w.kind == tbrk_pkg::KIND_LOAD) begin
      orbit_st = w.comp;
    end else begin
      x = orbit_st;
      h = {22'd0, step_h};
      all_zero = 1'b1;
      orbit_rate(x, k1);
      rk4_stage(x, k1, tbrk_pkg::FRAC_BITS + 1, t);
      orbit_rate(t, k2);
      rk4_stage(x, k2, tbrk_pkg::FRAC_BITS + 1, t);
      orbit_rate(t, k3);
      rk4_stage(x, k3, tbrk_pkg::FRAC_BITS, t);
      orbit_rate(t, k4);
      for (int i = 0; i < 6; i++) begin
        sum = fx_add(fx_add(fx_add(k1[i], fx_add(k2[i], k2[i])),
                            fx_add(k3[i], k3[i])), k4[i]);
        p = fx_mul(sum, h, tbrk_pkg::FRAC_BITS);
        d[i] = fx_pack({64'd0, (fx_abs(p) + 64'd3) / 64'd6}, p[63]);
        if (d[i] != 0) all_zero = 1'b0;
      end
      if (all_zero) res.stalled = 1'b1;
      else for (int i = 0; i < 6; i++) orbit_st[i] = fx_add(x[i], d[i]);
    end
    res.comp = orbit_st;
    res.saturated = step_sat;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: hold each word until taken, random gaps between words
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    orbit_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        w.kind = req_ch.kind;
        w.comp = '{req_ch.load_px, req_ch.load_py, req_ch.load_pz,
                   req_ch.load_vx, req_ch.load_vy, req_ch.load_vz};
        state_expect_q.push_back(predict_orbit(w));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (orbit_pending.size() > 0) begin
          w = orbit_pending.pop_front();
          req_ch.kind    <= w.kind;
          req_ch.load_px <= w.comp[0];
          req_ch.load_py <= w.comp[1];
          req_ch.load_pz <= w.comp[2];
          req_ch.load_vx <= w.comp[3];
          req_ch.load_vy <= w.comp[4];
          req_ch.load_vz <= w.comp[5];
          req_ch.valid   <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // response monitor: compare each word with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    orbit_result_t e;
    word_t         got [6];
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.out_px, rsp_ch.out_py, rsp_ch.out_pz,
                rsp_ch.out_vx, rsp_ch.out_vy, rsp_ch.out_vz};
        if (state_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none actual px %h", $realtime,
                   got[0]);
        end else begin
          e = state_expect_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (got[i] !== e.comp[i]) begin
              errors++;
              $display("%0t: state[%0d] expected %h actual %h", $realtime, i, e.comp[i],
                       got[i]);
            end
          if (rsp_ch.stalled !== e.stalled) begin
            errors++;
            $display("%0t: stalled expected %b actual %b", $realtime, e.stalled,
                     rsp_ch.stalled);
          end
          if (rsp_ch.saturated !== e.saturated) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $realtime, e.saturated,
                     rsp_ch.saturated);
          end
        end
      end
      // random back-pressure
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_load(input word_t px, py, pz, vx, vy, vz);
    orbit_word_t w;
    w.kind = tbrk_pkg::KIND_LOAD;
    w.comp = '{px, py, pz, vx, vy, vz};
    orbit_pending.push_back(w);
  endfunction

  function automatic void queue_steps(input int n);
    orbit_word_t w;
    w.kind = tbrk_pkg::KIND_STEP;
    for (int i = 0; i < 6; i++) w.comp[i] = {$urandom, $urandom};
    repeat (n) orbit_pending.push_back(w);
  endfunction

  // km or km/s value with a random fraction, magnitude below lim + 1
  function automatic word_t rand_q(input int unsigned lim);
    word_t v;
    v = {1'b0, 31'($urandom_range(0, lim)), 32'($urandom)};
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic word_t rand_raw();
    return {$urandom, $urandom};
  endfunction

  task automatic wait_idle();
    while (orbit_pending.size() > 0 || req_ch.valid || state_expect_q.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [tbrk_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == tbrk_pkg::REG_STEP) step_h = val[41:0];
    else grav_mu = val[61:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_mix(input int n);
    int r;
    for (int i = 0; i < n; ) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        // plausible orbit followed by a few steps
        queue_load(rand_q(42000), rand_q(42000), rand_q(42000),
                   rand_q(8), rand_q(8), rand_q(8));
        r = $urandom_range(1, 3);
        queue_steps(r);
        i += r + 1;
      end else if (r < 93) begin
        queue_load(rand_raw(), rand_raw(), rand_raw(), rand_raw(), rand_raw(), rand_raw());
        queue_steps(1);
        i += 2;
      end else if (r < 97) begin
        queue_load(0, 0, 0, rand_q(8), rand_q(8), rand_q(8));
        queue_steps(1);
        i += 2;
      end else begin
        queue_steps(1);
        i += 1;
      end
    end
  endtask

  initial begin
    word_t leo_r, leo_v, geo_r;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = tbrk_pkg::REG_STEP;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.kind  = tbrk_pkg::KIND_LOAD;
    req_ch.load_px = '0;
    req_ch.load_py = '0;
    req_ch.load_pz = '0;
    req_ch.load_vx = '0;
    req_ch.load_vy = '0;
    req_ch.load_vz = '0;
    rsp_ch.ready = 1'b0;
    orbit_st = '{default: '0};
    step_h   = tbrk_pkg::STEP_RESET;
    grav_mu  = tbrk_pkg::MU_RESET;
    leo_r = 64'sd7000 <<< 32;
    leo_v = 64'sd32212254720;  // 7.5 km/s
    geo_r = 64'sd42164 <<< 32;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: zero radius, extremes, a circular orbit
    queue_steps(1);
    queue_load(0, 0, 0, 0, 0, 0);
    queue_steps(1);
    queue_load(tbrk_pkg::S64_MAX, tbrk_pkg::S64_MAX, tbrk_pkg::S64_MAX,
               tbrk_pkg::S64_MAX, tbrk_pkg::S64_MAX, tbrk_pkg::S64_MAX);
    queue_steps(1);
    queue_load(tbrk_pkg::S64_MIN, tbrk_pkg::S64_MIN, tbrk_pkg::S64_MIN,
               tbrk_pkg::S64_MIN, tbrk_pkg::S64_MIN, tbrk_pkg::S64_MIN);
    queue_steps(1);
    queue_load(leo_r, 0, 0, 0, leo_v, 0);
    queue_steps(3);
    queue_load(0, -leo_r, 0, -leo_v, 0, 0);
    queue_steps(2);
    queue_load(0, 0, 0, leo_v, -leo_v, leo_v);
    queue_steps(1);
    queue_load(1, -1, 1, -1, 1, -1);
    queue_steps(1);
    wait_idle();

    // tiny step: far body at rest moves by less than one lsb
    write_reg(tbrk_pkg::REG_STEP, 62'd1);
    queue_load(geo_r, 0, 0, 0, 0, 0);
    queue_steps(2);
    queue_load(leo_r, leo_r, 0, leo_v, 0, 0);
    queue_steps(1);
    calm = 1'b1;
    random_mix(200);
    wait_idle();

    // out-of-range step: only the low 42 bits count, giving zero
    calm = 1'b0;
    write_reg(tbrk_pkg::REG_STEP, 62'd1 << 42);
    queue_load(leo_r, 0, 0, 0, leo_v, 0);
    queue_steps(1);
    random_mix(120);
    wait_idle();

    // large step: 1000 with 32 fraction bits
    write_reg(tbrk_pkg::REG_STEP, 62'd4294967296000);
    random_mix(200);
    wait_idle();

    write_reg(tbrk_pkg::REG_STEP, tbrk_pkg::STEP_RESET);
    write_reg(tbrk_pkg::REG_MU, 62'd1);
    random_mix(200);
    wait_idle();

    write_reg(tbrk_pkg::REG_MU, {62{1'b1}});
    random_mix(200);
    wait_idle();

    write_reg(tbrk_pkg::REG_MU, tbrk_pkg::MU_RESET);
    random_mix(300);
    wait_idle();

    write_reg(tbrk_pkg::REG_STEP, 62'($urandom_range(1, 32'h7FFF_FFFF)));
    write_reg(tbrk_pkg::REG_MU, {30'($urandom), 32'($urandom)});
    random_mix(300);
    wait_idle();

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #400000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/tbrk_pkg.sv
design/tbrk_req_if.sv
design/tbrk_rsp_if.sv
design/tbrk_mul.sv
design/tbrk_div.sv
design/tbrk_sqrt.sv
design/two_body_rk4_orbit_step_unit.sv
sim/tb_two_body_rk4_orbit_step_unit.sv
